// ----- hw/rtl/tsm_pkg.sv -----
package tsm_pkg;

    // Read requests longer than this are cut to it.
    localparam logic [15:0] MAX_READ_BYTES = 16'd32768;

    // Field widths.
    localparam int POS_W   = 40;
    localparam int FRAME_W = 32;
    localparam int FB_W    = 13;
    localparam int FIH_W   = 9;
    localparam int LEN_W   = 16;
    localparam int HB_W    = 20;
    localparam int SEEK_W  = 41;
    localparam int CFG_IDX_W = 3;

    // Saturation limits applied to the size registers before use.
    localparam logic [FB_W-1:0]  BYTES_MIN = 13'd1024;
    localparam logic [FB_W-1:0]  BYTES_MAX = 13'd4096;
    localparam logic [FIH_W-1:0] FIH_MIN   = 9'd1;
    localparam logic [FIH_W-1:0] FIH_MAX   = 9'd256;

    // Reset values of the configuration registers.
    localparam logic [FB_W-1:0]  FB_RESET  = 13'd2352;
    localparam logic [FIH_W-1:0] FIH_RESET = 9'd8;
    localparam logic [FB_W-1:0]  US_RESET  = 13'd2448;

    // Serial divider: one quotient bit per cycle over the full dividend.
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request operations.
    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_SEEK_ABS = 2'd1,
        OP_SEEK_REL = 2'd2,
        OP_SEEK_END = 2'd3
    } op_e_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PREGAP_END = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_END  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_HUNK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_STRIDE = 3'd5;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [FB_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [POS_W-1:0] quotient;
        logic [FB_W-1:0]  remainder;
    } div_resp_t;

endpackage

// ----- hw/rtl/tsm_div.sv -----
module tsm_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsm_pkg::div_req_t  req,
    output tsm_pkg::div_resp_t resp
);
    import tsm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0]     quot_reg;
    logic [FB_W-1:0]      rem_reg;
    logic [FB_W-1:0]      dvs_reg;

    logic [FB_W:0]        trial;
    logic [FB_W:0]        diff;
    logic                 fits;

    // Bring down the next dividend bit and try a subtraction.
    assign trial = {rem_reg, quot_reg[POS_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg  <= '0;
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
            quot_reg <= {quot_reg[POS_W-2:0], fits};
            rem_reg  <= fits ? diff[FB_W-1:0] : trial[FB_W-1:0];
        end
    end

    assign resp.busy      = busy_reg;
    assign resp.done      = done_reg;
    assign resp.quotient  = quot_reg;
    assign resp.remainder = rem_reg;

endmodule

// ----- hw/rtl/track_read_segment_mapper.sv -----
// Track read segment mapper.
// Keeps a byte cursor into one disc-image track. Requests arrive on the s_
// channel (valid/ready) as read or seek items; results leave on the m_
// channel (valid/ready), one per seek, one per frame segment of a read and
// one for an empty read, with m_last marking the final result of a request.
// The user must write registers through the cfg_ channel only while the
// block is idle; the block itself does not enforce it. cfg_ready is always high.
// One request is worked on at a time; s_ready is high only between requests.
// A seek adds its amount to its base and then loads its result. A read
// clamps its length and finds the offset inside the first frame, then
// emits its pregap segments directly and works out the hunk and hunk byte
// of each data segment with the shared divider, which yields one quotient
// bit per cycle over a 40-bit dividend, and a 9-step shift-add multiplier.
// A result sits in an output register; while the receiver stalls the block
// finishes the work for the next result and then holds until the register
// is taken. Reset clears the cursor and the hunk cache and returns every
// configuration register to its reset value; no clearing pass is needed.
module track_read_segment_mapper (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_operation,
    input  logic [tsm_pkg::LEN_W-1:0]              s_read_length,
    input  logic signed [tsm_pkg::SEEK_W-1:0]      s_seek_amount,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_status,
    output logic                                   m_zero_fill,
    output logic [tsm_pkg::FRAME_W-1:0]            m_hunk_index,
    output logic [tsm_pkg::HB_W-1:0]               m_hunk_byte,
    output logic [tsm_pkg::FB_W-1:0]               m_segment_bytes,
    output logic                                   m_needs_load,
    output logic [tsm_pkg::LEN_W-1:0]              m_granted_bytes,
    output logic [tsm_pkg::POS_W-1:0]              m_cursor_after,
    output logic                                   m_last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tsm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tsm_pkg::POS_W-1:0]              cfg_data
);
    import tsm_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SK_ADD   = 12'b0000_0000_0010,
        ST_SK_FIN   = 12'b0000_0000_0100,
        ST_RD_AVAIL = 12'b0000_0000_1000,
        ST_RD_WANT  = 12'b0000_0001_0000,
        ST_RD_CHK   = 12'b0000_0010_0000,
        ST_RD_FO    = 12'b0000_0100_0000,
        ST_SEG      = 12'b0000_1000_0000,
        ST_DIV_FR   = 12'b0001_0000_0000,
        ST_DIV_HK   = 12'b0010_0000_0000,
        ST_MUL      = 12'b0100_0000_0000,
        ST_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [POS_W-1:0]   pregap_end_reg;
    logic [POS_W-1:0]   end_byte_reg;
    logic [FRAME_W-1:0] first_frame_reg;
    logic [FB_W-1:0]    frame_bytes_reg;
    logic [FIH_W-1:0]   frames_hunk_reg;
    logic [FB_W-1:0]    unit_stride_reg;

    // Persistent state.
    logic [POS_W-1:0]   cursor_reg;
    logic [FRAME_W-1:0] cached_hunk_reg;
    logic               cached_valid_reg;

    // Per-request working registers.
    op_e_t                    op_reg;
    logic [LEN_W-1:0]         len_reg;
    logic signed [SEEK_W-1:0] seek_reg;
    logic [POS_W+1:0]         target_reg;
    logic [POS_W-1:0]         avail_reg;
    logic [LEN_W-1:0]         granted_reg;
    logic [LEN_W-1:0]         remain_reg;
    logic [FB_W-1:0]          fo_reg;
    logic [FB_W-1:0]          amt_reg;
    logic                     zf_reg;
    logic [FRAME_W-1:0]       hunk_reg;
    logic [HB_W-1:0]          acc_reg;
    logic [HB_W-1:0]          mcand_reg;
    logic [FIH_W-1:0]         mplier_reg;
    logic [3:0]               mcnt_reg;

    // Output register.
    logic               m_valid_reg;
    logic               m_status_reg;
    logic               m_zero_fill_reg;
    logic [FRAME_W-1:0] m_hunk_index_reg;
    logic [HB_W-1:0]    m_hunk_byte_reg;
    logic [FB_W-1:0]    m_segment_bytes_reg;
    logic               m_needs_load_reg;
    logic [LEN_W-1:0]   m_granted_bytes_reg;
    logic [POS_W-1:0]   m_cursor_after_reg;
    logic               m_last_reg;

    div_req_t  div_req;
    div_resp_t div_resp;

    logic [FB_W-1:0]    fb_c;
    logic [FIH_W-1:0]   fih_c;
    logic [FB_W-1:0]    us_c;
    logic               out_free;
    logic               out_load;
    logic               s_accept;
    logic [POS_W-1:0]   seek_base;
    logic [POS_W:0]     avail_diff;
    logic [LEN_W-1:0]   len_c;
    logic [LEN_W-1:0]   want;
    logic [FB_W-1:0]    span;
    logic [FB_W-1:0]    seg_amt;
    logic [FRAME_W-1:0] frame;
    logic [POS_W-1:0]   cursor_adv;
    logic               seg_last;
    logic               seg_load;
    logic               seek_neg;
    logic               seek_over;

    tsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    // Saturate the size registers into their legal ranges.
    assign fb_c  = (frame_bytes_reg < BYTES_MIN) ? BYTES_MIN :
                   (frame_bytes_reg > BYTES_MAX) ? BYTES_MAX : frame_bytes_reg;
    assign us_c  = (unit_stride_reg < BYTES_MIN) ? BYTES_MIN :
                   (unit_stride_reg > BYTES_MAX) ? BYTES_MAX : unit_stride_reg;
    assign fih_c = (frames_hunk_reg < FIH_MIN) ? FIH_MIN :
                   (frames_hunk_reg > FIH_MAX) ? FIH_MAX : frames_hunk_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // Read length clamping.
    assign avail_diff = {1'b0, end_byte_reg} - {1'b0, cursor_reg};
    assign len_c      = (len_reg > MAX_READ_BYTES) ? MAX_READ_BYTES : len_reg;
    assign want       = (avail_reg < {{(POS_W-LEN_W){1'b0}}, len_c}) ?
                        avail_reg[LEN_W-1:0] : len_c;

    // Segment length: to the next frame boundary or to the end of the read.
    assign span    = fb_c - fo_reg;
    assign seg_amt = (remain_reg < {{(LEN_W-FB_W){1'b0}}, span}) ?
                     remain_reg[FB_W-1:0] : span;

    // Image frame index wraps at 32 bits.
    assign frame = first_frame_reg + div_resp.quotient[FRAME_W-1:0];

    assign cursor_adv = cursor_reg + {{(POS_W-FB_W){1'b0}}, amt_reg};
    assign seg_last   = (remain_reg == {{(LEN_W-FB_W){1'b0}}, amt_reg});
    assign seg_load   = (state_reg == ST_EMIT) && out_free;

    // Seek target checks.
    assign seek_neg  = target_reg[POS_W+1];
    assign seek_over = target_reg[POS_W:0] > {1'b0, end_byte_reg};

    always_comb begin
        unique case (op_reg)
            OP_SEEK_REL: seek_base = cursor_reg;
            OP_SEEK_END: seek_base = end_byte_reg;
            default:     seek_base = '0;
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = cursor_reg;
        div_req.divisor  = fb_c;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (op_e_t'(s_operation) == OP_READ) ? ST_RD_AVAIL : ST_SK_ADD;
                end
            end
            ST_SK_ADD: state_next = ST_SK_FIN;
            ST_SK_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_AVAIL: state_next = ST_RD_WANT;
            ST_RD_WANT:  state_next = ST_RD_CHK;
            ST_RD_CHK: begin
                if (remain_reg == '0) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_RD_FO;
                end
            end
            ST_RD_FO: begin
                if (div_resp.done) begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG: begin
                if (cursor_reg < pregap_end_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = cursor_reg - pregap_end_reg;
                    state_next       = ST_DIV_FR;
                end
            end
            ST_DIV_FR: begin
                if (div_resp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(POS_W-FRAME_W){1'b0}}, frame};
                    div_req.divisor  = {{(FB_W-FIH_W){1'b0}}, fih_c};
                    state_next       = ST_DIV_HK;
                end
            end
            ST_DIV_HK: begin
                if (div_resp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mcnt_reg == 4'(FIH_W - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = seg_last ? ST_IDLE : ST_SEG;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and persistent state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            cursor_reg       <= '0;
            cached_hunk_reg  <= '0;
            cached_valid_reg <= 1'b0;
            pregap_end_reg   <= '0;
            end_byte_reg     <= '0;
            first_frame_reg  <= '0;
            frame_bytes_reg  <= FB_RESET;
            frames_hunk_reg  <= FIH_RESET;
            unit_stride_reg  <= US_RESET;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Register writes.
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PREGAP_END:  pregap_end_reg  <= cfg_data;
                    CFG_TRACK_END:   end_byte_reg    <= cfg_data;
                    CFG_FIRST_FRM:   first_frame_reg <= cfg_data[FRAME_W-1:0];
                    CFG_FRAME_BYTES: frame_bytes_reg <= cfg_data[FB_W-1:0];
                    CFG_FRAMES_HUNK: frames_hunk_reg <= cfg_data[FIH_W-1:0];
                    CFG_UNIT_STRIDE: unit_stride_reg <= cfg_data[FB_W-1:0];
                    default: ;
                endcase
            end

            // Seek commits a nonnegative target, clamped to the track end.
            if (state_reg == ST_SK_FIN && out_free && !seek_neg) begin
                cursor_reg <= seek_over ? end_byte_reg : target_reg[POS_W-1:0];
            end

            // A segment advances the cursor; data segments update the cache.
            if (seg_load) begin
                cursor_reg <= cursor_adv;
                if (!zf_reg) begin
                    cached_hunk_reg  <= hunk_reg;
                    cached_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers of the request in progress.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= op_e_t'(s_operation);
            len_reg  <= s_read_length;
            seek_reg <= s_seek_amount;
        end

        if (state_reg == ST_SK_ADD) begin
            target_reg <= {2'b00, seek_base} + {seek_reg[SEEK_W-1], seek_reg};
        end

        if (state_reg == ST_RD_AVAIL) begin
            avail_reg <= avail_diff[POS_W] ? '0 : avail_diff[POS_W-1:0];
        end

        if (state_reg == ST_RD_WANT) begin
            granted_reg <= want;
            remain_reg  <= want;
        end

        if (state_reg == ST_RD_FO && div_resp.done) begin
            fo_reg <= div_resp.remainder;
        end

        if (state_reg == ST_SEG) begin
            amt_reg <= seg_amt;
            zf_reg  <= cursor_reg < pregap_end_reg;
            hunk_reg <= '0;
            acc_reg  <= '0;
        end

        // Frame within hunk times stride, plus the offset inside the frame.
        if (state_reg == ST_DIV_HK && div_resp.done) begin
            hunk_reg   <= div_resp.quotient[FRAME_W-1:0];
            acc_reg    <= {{(HB_W-FB_W){1'b0}}, fo_reg};
            mcand_reg  <= {{(HB_W-FB_W){1'b0}}, us_c};
            mplier_reg <= div_resp.remainder[FIH_W-1:0];
            mcnt_reg   <= '0;
        end

        if (state_reg == ST_MUL) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[HB_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[FIH_W-1:1]};
            mcnt_reg   <= mcnt_reg + 4'd1;
        end

        // Later segments start on a frame boundary.
        if (seg_load) begin
            remain_reg <= remain_reg - {{(LEN_W-FB_W){1'b0}}, amt_reg};
            fo_reg     <= '0;
        end
    end

    // Output register load.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg        <= 1'b0;
            m_zero_fill_reg     <= 1'b0;
            m_hunk_index_reg    <= '0;
            m_hunk_byte_reg     <= '0;
            m_segment_bytes_reg <= '0;
            m_needs_load_reg    <= 1'b0;
            m_granted_bytes_reg <= '0;
            m_cursor_after_reg  <= cursor_reg;
            m_last_reg          <= 1'b1;
            if (state_reg == ST_SK_FIN) begin
                m_status_reg <= seek_neg;
                if (!seek_neg) begin
                    m_cursor_after_reg <= seek_over ? end_byte_reg :
                                          target_reg[POS_W-1:0];
                end
            end else if (state_reg == ST_EMIT) begin
                m_zero_fill_reg     <= zf_reg;
                m_hunk_index_reg    <= hunk_reg;
                m_hunk_byte_reg     <= acc_reg;
                m_segment_bytes_reg <= amt_reg;
                m_needs_load_reg    <= !zf_reg &&
                                       (!cached_valid_reg || cached_hunk_reg != hunk_reg);
                m_granted_bytes_reg <= granted_reg;
                m_cursor_after_reg  <= cursor_adv;
                m_last_reg          <= seg_last;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_zero_fill     = m_zero_fill_reg;
    assign m_hunk_index    = m_hunk_index_reg;
    assign m_hunk_byte     = m_hunk_byte_reg;
    assign m_segment_bytes = m_segment_bytes_reg;
    assign m_needs_load    = m_needs_load_reg;
    assign m_granted_bytes = m_granted_bytes_reg;
    assign m_cursor_after  = m_cursor_after_reg;
    assign m_last          = m_last_reg;

    // The divider is only started when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_resp.busy)
        else $error("divider started while busy");

    // A result never overwrites one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // Every read segment is nonempty and fits in what is left of the read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        seg_load |-> (amt_reg != '0 &&
                      {{(LEN_W-FB_W){1'b0}}, amt_reg} <= remain_reg))
        else $error("segment length out of range");

    // A finished read leaves nothing remaining.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (seg_load && seg_last) |=> (remain_reg == '0 && state_reg == ST_IDLE))
        else $error("read ended with bytes remaining");

endmodule

// ----- bench/segment_checker.sv -----
// Watches the request, result and register channels of the segment mapper.
// It keeps its own copy of the registers, the cursor and the hunk cache. It
// predicts the results of every accepted request item and compares each
// accepted result item with the oldest prediction.
module segment_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [tsm_pkg::LEN_W-1:0]           s_read_length,
    input  logic signed [tsm_pkg::SEEK_W-1:0]   s_seek_amount,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_status,
    input  logic                                m_zero_fill,
    input  logic [tsm_pkg::FRAME_W-1:0]         m_hunk_index,
    input  logic [tsm_pkg::HB_W-1:0]            m_hunk_byte,
    input  logic [tsm_pkg::FB_W-1:0]            m_segment_bytes,
    input  logic                                m_needs_load,
    input  logic [tsm_pkg::LEN_W-1:0]           m_granted_bytes,
    input  logic [tsm_pkg::POS_W-1:0]           m_cursor_after,
    input  logic                                m_last,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsm_pkg::POS_W-1:0]           cfg_data,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_seen,
    output int                                  pregap_segments,
    output int                                  rejected_seeks
);
    import tsm_pkg::*;

    typedef struct packed {
        logic               status;
        logic               zero_fill;
        logic [FRAME_W-1:0] hunk_index;
        logic [HB_W-1:0]    hunk_byte;
        logic [FB_W-1:0]    segment_bytes;
        logic               needs_load;
        logic [LEN_W-1:0]   granted_bytes;
        logic [POS_W-1:0]   cursor_after;
        logic               last;
    } seg_result_t;

    // Register copies.
    logic [POS_W-1:0]   reg_pregap;
    logic [POS_W-1:0]   reg_end_byte;
    logic [FRAME_W-1:0] reg_first_frame;
    logic [FB_W-1:0]    reg_frame_bytes;
    logic [FIH_W-1:0]   reg_frames_hunk;
    logic [FB_W-1:0]    reg_stride;

    // Track state.
    logic [POS_W-1:0]   cursor_pos;
    logic [FRAME_W-1:0] last_hunk;
    logic               last_hunk_ok;

    seg_result_t pending_segments[$];
    seg_result_t oldest;

    function automatic logic [63:0] clamp_size(logic [63:0] v, logic [63:0] lo,
                                               logic [63:0] hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Cuts a read at frame boundaries and queues one result per segment.
    task automatic map_read(input logic [LEN_W-1:0] req_len);
        logic [63:0] fb, fih, stride, want, avail, pos, stop;
        logic [63:0] fo, amount, frame, hunk, hb;
        seg_result_t r;
        fb = clamp_size(64'(reg_frame_bytes), 64'(BYTES_MIN), 64'(BYTES_MAX));
        fih = clamp_size(64'(reg_frames_hunk), 64'(FIH_MIN), 64'(FIH_MAX));
        stride = clamp_size(64'(reg_stride), 64'(BYTES_MIN), 64'(BYTES_MAX));
        want = 64'(req_len);
        if (want > 64'(MAX_READ_BYTES)) begin
            want = 64'(MAX_READ_BYTES);
        end
        pos = 64'(cursor_pos);
        avail = (pos < 64'(reg_end_byte)) ? 64'(reg_end_byte) - pos : 64'd0;
        if (want > avail) begin
            want = avail;
        end
        if (want == 0) begin
            // Nothing to read: a single empty result.
            r = '0;
            r.cursor_after = cursor_pos;
            r.last = 1'b1;
            pending_segments.push_back(r);
        end else begin
            stop = pos + want;
            while (pos < stop) begin
                fo = pos % fb;
                amount = fb - fo;
                if (amount > stop - pos) begin
                    amount = stop - pos;
                end
                r = '0;
                if (pos < 64'(reg_pregap)) begin
                    // A segment that starts in the pregap is zeros as a whole.
                    r.zero_fill = 1'b1;
                    pregap_segments++;
                end else begin
                    frame = (64'(reg_first_frame) + (pos - 64'(reg_pregap)) / fb) &
                            64'hFFFF_FFFF;
                    hunk = frame / fih;
                    hb = (frame % fih) * stride + fo;
                    r.hunk_index = hunk[FRAME_W-1:0];
                    r.hunk_byte = hb[HB_W-1:0];
                    r.needs_load = !last_hunk_ok || (last_hunk != hunk[FRAME_W-1:0]);
                    last_hunk = hunk[FRAME_W-1:0];
                    last_hunk_ok = 1'b1;
                end
                pos = pos + amount;
                r.segment_bytes = amount[FB_W-1:0];
                r.granted_bytes = want[LEN_W-1:0];
                r.cursor_after = pos[POS_W-1:0];
                r.last = (pos >= stop);
                pending_segments.push_back(r);
            end
            cursor_pos = pos[POS_W-1:0];
        end
    endtask

    // Moves the cursor for a seek; a negative target leaves it in place.
    task automatic apply_seek(input op_e_t op, input logic signed [SEEK_W-1:0] amount);
        longint target;
        seg_result_t r;
        case (op)
            OP_SEEK_ABS: begin
                target = longint'(amount);
            end
            OP_SEEK_REL: begin
                target = $signed({24'd0, cursor_pos}) + longint'(amount);
            end
            default: begin
                target = $signed({24'd0, reg_end_byte}) + longint'(amount);
            end
        endcase
        r = '0;
        r.last = 1'b1;
        if (target < 0) begin
            r.status = 1'b1;
            rejected_seeks++;
        end else if (target > $signed({24'd0, reg_end_byte})) begin
            cursor_pos = reg_end_byte;
        end else begin
            cursor_pos = target[POS_W-1:0];
        end
        r.cursor_after = cursor_pos;
        pending_segments.push_back(r);
    endtask

    function automatic void check_field(string name, logic [63:0] want_v,
                                        logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_pregap = '0;
            reg_end_byte = '0;
            reg_first_frame = '0;
            reg_frame_bytes = FB_RESET;
            reg_frames_hunk = FIH_RESET;
            reg_stride = US_RESET;
            cursor_pos = '0;
            last_hunk = '0;
            last_hunk_ok = 1'b0;
            pending_segments.delete();
            mismatches = 0;
            results_seen = 0;
            pregap_segments = 0;
            rejected_seeks = 0;
            outstanding <= 0;
        end else begin
            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PREGAP_END:  reg_pregap = cfg_data;
                    CFG_TRACK_END:   reg_end_byte = cfg_data;
                    CFG_FIRST_FRM:   reg_first_frame = cfg_data[FRAME_W-1:0];
                    CFG_FRAME_BYTES: reg_frame_bytes = cfg_data[FB_W-1:0];
                    CFG_FRAMES_HUNK: reg_frames_hunk = cfg_data[FIH_W-1:0];
                    CFG_UNIT_STRIDE: reg_stride = cfg_data[FB_W-1:0];
                    default: ;
                endcase
            end

            // Compare a result item with the oldest prediction.
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_segments.size() == 0) begin
                    $display("%0t: result item with nothing expected, %s, got cursor %0d",
                             $time, "expected none", m_cursor_after);
                    mismatches++;
                end else begin
                    oldest = pending_segments.pop_front();
                    check_field("status", oldest.status, m_status);
                    check_field("zero_fill", oldest.zero_fill, m_zero_fill);
                    check_field("hunk_index", oldest.hunk_index, m_hunk_index);
                    check_field("hunk_byte", oldest.hunk_byte, m_hunk_byte);
                    check_field("segment_bytes", oldest.segment_bytes, m_segment_bytes);
                    check_field("needs_load", oldest.needs_load, m_needs_load);
                    check_field("granted_bytes", oldest.granted_bytes, m_granted_bytes);
                    check_field("cursor_after", oldest.cursor_after, m_cursor_after);
                    check_field("last", oldest.last, m_last);
                end
            end

            // Predict the results of a request item.
            if (s_valid && s_ready) begin
                case (op_e_t'(s_operation))
                    OP_READ: map_read(s_read_length);
                    default: apply_seek(op_e_t'(s_operation), s_seek_amount);
                endcase
            end
            outstanding <= pending_segments.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    import tsm_pkg::*;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_operation = OP_READ;
    logic [LEN_W-1:0]         s_read_length = '0;
    logic signed [SEEK_W-1:0] s_seek_amount = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_status;
    logic                     m_zero_fill;
    logic [FRAME_W-1:0]       m_hunk_index;
    logic [HB_W-1:0]          m_hunk_byte;
    logic [FB_W-1:0]          m_segment_bytes;
    logic                     m_needs_load;
    logic [LEN_W-1:0]         m_granted_bytes;
    logic [POS_W-1:0]         m_cursor_after;
    logic                     m_last;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_PREGAP_END;
    logic [POS_W-1:0]         cfg_data = '0;

    int mismatches, outstanding, results_seen, pregap_segments, rejected_seeks;
    int requests_sent = 0;
    int track_settings = 0;
    bit steady_flow = 1'b0;

    // Track limits currently programmed, used to aim seeks.
    logic [POS_W-1:0] cur_pregap = '0;
    logic [POS_W-1:0] cur_end_byte = '0;

    track_read_segment_mapper dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_read_length  (s_read_length),
        .s_seek_amount  (s_seek_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_zero_fill    (m_zero_fill),
        .m_hunk_index   (m_hunk_index),
        .m_hunk_byte    (m_hunk_byte),
        .m_segment_bytes(m_segment_bytes),
        .m_needs_load   (m_needs_load),
        .m_granted_bytes(m_granted_bytes),
        .m_cursor_after (m_cursor_after),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    segment_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_read_length  (s_read_length),
        .s_seek_amount  (s_seek_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_zero_fill    (m_zero_fill),
        .m_hunk_index   (m_hunk_index),
        .m_hunk_byte    (m_hunk_byte),
        .m_segment_bytes(m_segment_bytes),
        .m_needs_load   (m_needs_load),
        .m_granted_bytes(m_granted_bytes),
        .m_cursor_after (m_cursor_after),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .pregap_segments(pregap_segments),
        .rejected_seeks (rejected_seeks)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver stalls now and then, except during the steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 14);
    end

    // Hard stop in case the block hangs.
    initial begin
        #16_000_000;
        $display("timeout while waiting for result items");
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [SEEK_W-1:0] noise_amount();
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        return r64[SEEK_W-1:0];
    endfunction

    // Offers one request item, after an occasional gap, and waits for it to be taken.
    task automatic send_request(input op_e_t op, input logic [LEN_W-1:0] len,
                                input logic signed [SEEK_W-1:0] amt);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 14) begin
            gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_read_length <= len;
        s_seek_amount <= amt;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic do_read(input logic [LEN_W-1:0] len);
        send_request(OP_READ, len, noise_amount());
    endtask

    task automatic do_seek(input op_e_t op, input logic signed [SEEK_W-1:0] amt);
        send_request(op, LEN_W'($urandom_range(0, 65535)), amt);
    endtask

    // Holds the sender off until every predicted result item has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic setup_track(input logic [POS_W-1:0] pregap, input logic [POS_W-1:0] end_pos,
                               input logic [FRAME_W-1:0] first, input logic [FB_W-1:0] fb,
                               input logic [FIH_W-1:0] fih, input logic [FB_W-1:0] stride);
        write_reg(CFG_PREGAP_END, pregap);
        write_reg(CFG_TRACK_END, end_pos);
        write_reg(CFG_FIRST_FRM, POS_W'(first));
        write_reg(CFG_FRAME_BYTES, POS_W'(fb));
        write_reg(CFG_FRAMES_HUNK, POS_W'(fih));
        write_reg(CFG_UNIT_STRIDE, POS_W'(stride));
        cfg_valid <= 1'b0;
        cur_pregap = pregap;
        cur_end_byte = end_pos;
        track_settings++;
    endtask

    // Mostly reads of modest size behind seeks aimed at the pregap edge and
    // the track end, with some rejected seeks and raw noise mixed in.
    task automatic random_request();
        int pick, roll, offs;
        logic [63:0] r64;
        op_e_t op;
        logic [LEN_W-1:0] len;
        logic signed [SEEK_W-1:0] amt;
        pick = $urandom_range(0, 99);
        len = LEN_W'($urandom_range(0, 65535));
        amt = noise_amount();
        if (pick < 50) begin
            op = OP_READ;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                len = '0;
            end else if (roll < 70) begin
                len = LEN_W'($urandom_range(1, 3000));
            end else if (roll < 88) begin
                len = LEN_W'($urandom_range(3000, 12000));
            end else if (roll < 95) begin
                len = LEN_W'($urandom_range(12000, 32768));
            end else begin
                len = LEN_W'($urandom_range(32769, 65535));
            end
        end else if (pick < 62) begin
            op = OP_SEEK_ABS;
            offs = $urandom_range(0, 10000);
            offs = offs - 5000;
            amt = $signed({1'b0, cur_pregap}) + SEEK_W'(offs);
        end else if (pick < 72) begin
            op = OP_SEEK_ABS;
            r64 = {$urandom, $urandom};
            r64 = r64 % ({24'd0, cur_end_byte} + 64'd1);
            amt = {1'b0, r64[POS_W-1:0]};
        end else if (pick < 80) begin
            op = OP_SEEK_END;
            offs = $urandom_range(0, 40000);
            amt = SEEK_W'(offs - 35000);
        end else if (pick < 90) begin
            op = OP_SEEK_REL;
            offs = $urandom_range(0, 40000);
            amt = SEEK_W'(offs - 20000);
        end else begin
            op = op_e_t'($urandom_range(1, 3));
        end
        send_request(op, len, amt);
    endtask

    initial begin
        logic [POS_W-1:0] pregap, end_pos;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Ordinary track layout; the pregap end is not on a frame boundary.
        setup_track(40'd353800, 40'd1765000, 32'd1500, 13'd2352, 9'd8, 13'd2448);
        do_read(16'd0);
        do_read(16'd100);
        do_seek(OP_SEEK_ABS, 41'sd353700);
        do_read(16'd5000);
        do_read(16'hFFFF);
        do_read(16'd32768);
        do_seek(OP_SEEK_REL, 41'sd3);
        do_read(16'd1);
        do_read(16'd1);
        do_seek(OP_SEEK_ABS, -41'sd1);
        do_seek(OP_SEEK_ABS, {1'b1, 40'd0});
        do_seek(OP_SEEK_ABS, {1'b0, {POS_W{1'b1}}});
        do_read(16'd10);
        do_seek(OP_SEEK_END, -41'sd3000);
        do_read(16'd4096);
        do_seek(OP_SEEK_END, 41'sd5);
        do_seek(OP_SEEK_REL, {1'b1, 40'd0});
        do_seek(OP_SEEK_END, -41'sd1765001);
        do_seek(OP_SEEK_END, {1'b0, {POS_W{1'b1}}});
        do_seek(OP_SEEK_REL, -41'sd1765000);
        do_read(16'd2352);
        repeat (20) random_request();
        drain();

        // Smallest frames, one frame per hunk, no pregap.
        setup_track(40'd0, 40'd5000000, 32'd0, 13'd1024, 9'd1, 13'd4096);
        repeat (32) random_request();
        drain();

        // Largest frames and hunks over the widest track; frame index wraps.
        setup_track(40'd12345, {POS_W{1'b1}}, 32'hFFFF_FF00, 13'd4096, 9'd256, 13'd1024);
        repeat (32) random_request();
        drain();

        // Size registers below range, whole track in pregap, no idling.
        steady_flow = 1'b1;
        setup_track({POS_W{1'b1}}, {POS_W{1'b1}}, 32'hFFFF_FFFF, 13'd0, 9'd0, 13'd0);
        repeat (32) random_request();
        drain();
        steady_flow = 1'b0;

        // Size registers above range, track high in the address space.
        setup_track(40'h80_0000_0000, 40'h80_002D_C6C0, 32'hFFFF_FFFF,
                    13'h1FFF, 9'h1FF, 13'h1FFF);
        repeat (32) random_request();
        drain();

        // Empty track: every read is empty.
        setup_track(40'd0, 40'd0, $urandom, FB_W'($urandom_range(1024, 4096)),
                    FIH_W'($urandom_range(1, 256)), FB_W'($urandom_range(1024, 4096)));
        repeat (12) random_request();
        drain();

        // Random layout.
        pregap = POS_W'($urandom_range(0, 1 << 20));
        end_pos = pregap + POS_W'($urandom_range(0, 1 << 24));
        setup_track(pregap, end_pos, $urandom, FB_W'($urandom_range(1024, 4096)),
                    FIH_W'($urandom_range(1, 256)), FB_W'($urandom_range(1024, 4096)));
        repeat (30) random_request();
        drain();

        // Give a stray result item time to show up.
        repeat (300) @(posedge aclk);

        $display("%0d requests over %0d track layouts, %0d result items compared",
                 requests_sent, track_settings, results_seen);
        $display("%0d pregap segments and %0d rejected seeks among them",
                 pregap_segments, rejected_seeks);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
